/* design/spq_pkg.sv */
// spq_pkg: shared types and constants of the sorted priority queue.
// No dependencies; compiled first.

package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRI_W  = 8;
    localparam int CAP_W  = 8;
    localparam int CNT_W  = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_op                       opcode;
        logic signed [DATA_W-1:0]  item_data;
        logic        [PRI_W-1:0]   item_priority;
    } t_req_word;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  head_data;
        logic        [PRI_W-1:0]   head_priority;
        logic        [CNT_W-1:0]   entry_count;
    } t_rsp_word;

    typedef logic [CAP_W-1:0] t_cfg_word;

    // one stored entry, as handed between neighbor cells
    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        logic        [PRI_W-1:0]   pri;
    } t_entry;

    // broadcast to every cell in the row
    typedef struct packed {
        logic    enq;
        logic    deq;
        t_entry  item;
    } t_cell_ctrl;

endpackage

/* design/spq_stream_if.sv */
// spq_stream_if: valid/ready channel carrying one word of type T.
// Depends on nothing; payload types come from spq_pkg at instantiation.

interface spq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* design/spq_cell.sv */
// spq_cell: one slot of the sorted row; holds an entry and shifts with its neighbors.
// Depends on spq_pkg.

module spq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 8
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctrl   i_ctrl,
    input  logic [CNT_W-1:0]      i_count,
    input  spq_pkg::t_entry       i_left,
    input  logic                  i_left_ins,
    input  spq_pkg::t_entry       i_right,
    output spq_pkg::t_entry       o_entry,
    output logic                  o_ins
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            w_valid;

    assign w_valid = i_count > CNT_W'(IDX);
    // new item lands at or before this slot (empty slots always count)
    assign o_ins   = !w_valid || (r_entry.pri > i_ctrl.item.pri);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq) begin
            if (i_left_ins) begin
                n_entry = i_left;
            end else if (o_ins) begin
                n_entry = i_ctrl.item;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* design/sorted_priority_queue.sv */
// sorted_priority_queue: top level, a row of spq_cell slots kept sorted by priority.
// Depends on spq_pkg, spq_stream_if and spq_cell.
//
// Usage:
//   i_req carries an enqueue (data + priority) or a dequeue word; o_rsp returns
//   one word per request: status, removed head data/priority, and the count
//   held afterwards. i_cfg writes the capacity register (reset 128); the
//   effective limit is the smaller of capacity and DEPTH.
// Timing:
//   The row of cells compares the new priority in parallel and shifts all
//   together, and the head is read straight from the first cell, so the
//   response is registered in the cycle after the request is accepted.
//   One request per cycle is sustained while o_rsp is ready.
// Stall:
//   o_rsp is held in an output register. A new request is taken while that
//   register is empty or being drained in the same cycle; otherwise i_req
//   ready drops until the receiver takes the pending word.
// Reset:
//   i_rst_n (synchronous, active low) empties the queue, clears the pending
//   response, restores capacity to 128 and holds both input readies low.
//   Cell contents are not cleared; slots beyond the count are never read.

module sorted_priority_queue #(
    parameter int DEPTH = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spq_stream_if.sink    i_req,
    spq_stream_if.source  o_rsp,
    spq_stream_if.sink    i_cfg
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    spq_pkg::t_cfg_word     r_cap;
    logic                   r_out_valid;
    spq_pkg::t_rsp_word     r_out;
    spq_pkg::t_rsp_word     n_out;

    spq_pkg::t_req_word     w_req;
    spq_pkg::t_cell_ctrl    w_ctrl;
    spq_pkg::t_entry        w_entry [DEPTH];
    logic                   w_ins   [DEPTH];
    logic [LW-1:0]          w_limit;
    logic                   w_acc;
    logic                   w_full;
    logic                   w_empty;

    assign w_req = i_req.data;

    // output register frees up when empty or drained this cycle
    assign i_req.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign w_acc       = i_req.valid && i_req.ready;

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign i_cfg.ready = i_rst_n;

    assign w_limit = (LW'(r_cap) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(r_cap);
    assign w_full  = LW'(r_count) >= w_limit;
    assign w_empty = r_count == '0;

    assign w_ctrl.enq       = w_acc && (w_req.opcode == spq_pkg::OP_ENQ) && !w_full;
    assign w_ctrl.deq       = w_acc && (w_req.opcode == spq_pkg::OP_DEQ) && !w_empty;
    assign w_ctrl.item.data = w_req.item_data;
    assign w_ctrl.item.pri  = w_req.item_priority;

    always_comb begin
        n_count             = r_count;
        n_out.status        = spq_pkg::ST_DONE;
        n_out.head_data     = '0;
        n_out.head_priority = '0;
        if (w_req.opcode == spq_pkg::OP_ENQ) begin
            if (w_full) begin
                n_out.status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                n_out.status = spq_pkg::ST_EMPTY;
            end else begin
                n_out.head_data     = w_entry[0].data;
                n_out.head_priority = w_entry[0].pri;
                n_count             = r_count - CW'(1);
            end
        end
        n_out.entry_count = spq_pkg::CNT_W'(n_count);
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            spq_pkg::t_entry w_left;
            spq_pkg::t_entry w_right;
            logic            w_left_ins;

            if (gi == 0) begin : g_head
                assign w_left     = w_ctrl.item;
                assign w_left_ins = 1'b0;
            end else begin : g_mid
                assign w_left     = w_entry[gi-1];
                assign w_left_ins = w_ins[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_right = w_entry[gi];
            end else begin : g_body
                assign w_right = w_entry[gi+1];
            end

            spq_cell #(
                .IDX   (gi),
                .CNT_W (CW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_count    (r_count),
                .i_left     (w_left),
                .i_left_ins (w_left_ins),
                .i_right    (w_right),
                .o_entry    (w_entry[gi]),
                .o_ins      (w_ins[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= spq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.data;
            end
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_count) <= LW'(DEPTH))
        else $error("count exceeds depth");

    a_deq_drops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.deq |=> (r_count == $past(r_count) - CW'(1)))
        else $error("dequeue did not remove one entry");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_req.opcode == spq_pkg::OP_ENQ) && w_full) |=> $stable(r_count))
        else $error("refused enqueue changed count");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_entry[0].pri <= w_entry[1].pri))
        else $error("head out of priority order");

endmodule
